@@ rtl/iva_pkg.sv @@
`timescale 1ns / 1ps

package iva_pkg;

	// Vector space and ranges
	localparam int VECTOR_COUNT = 256;
	localparam int OS_BASE      = 32;
	localparam int EXT_BASE     = 48;
	localparam int EXT_END      = 256;
	localparam int HANDLER_BITS = 16;

	localparam int VEC_W      = 8;
	localparam int STORE_SIZE = 256;
	localparam int BYTE_W     = VEC_W - 3;
	localparam int MAP_BITS   = EXT_END - OS_BASE;
	localparam int MAP_IDX_W  = $clog2(MAP_BITS);

	// Byte windows of the bitmap scan
	localparam int OS_TOP  = (EXT_BASE < VECTOR_COUNT) ? EXT_BASE : VECTOR_COUNT;
	localparam int EXT_TOP = (EXT_END < VECTOR_COUNT) ? EXT_END : VECTOR_COUNT;
	localparam logic [BYTE_W-1:0] OS_FIRST_BYTE  = BYTE_W'(OS_BASE / 8);
	localparam logic [BYTE_W-1:0] OS_LAST_BYTE   =
		BYTE_W'(((OS_TOP > OS_BASE ? OS_TOP : OS_BASE + 1) - 1) / 8);
	localparam logic [BYTE_W-1:0] EXT_FIRST_BYTE = BYTE_W'(EXT_BASE / 8);
	localparam logic [BYTE_W-1:0] EXT_LAST_BYTE  =
		BYTE_W'(((EXT_TOP > EXT_BASE ? EXT_TOP : EXT_BASE + 1) - 1) / 8);

	// Operation codes
	localparam logic [2:0] OP_ALLOC_OS  = 3'd0;
	localparam logic [2:0] OP_ALLOC_EXT = 3'd1;
	localparam logic [2:0] OP_FREE      = 3'd2;
	localparam logic [2:0] OP_BIND      = 3'd3;
	localparam logic [2:0] OP_GET       = 3'd4;

	function automatic logic vec_exists(input logic [VEC_W-1:0] v);
		return {1'b0, v} < 9'(VECTOR_COUNT);
	endfunction

	function automatic logic vec_has_mark(input logic [VEC_W-1:0] v);
		return ({1'b0, v} >= 9'(OS_BASE)) && ({1'b0, v} < 9'(EXT_END));
	endfunction

	function automatic logic [MAP_IDX_W-1:0] map_index(input logic [VEC_W-1:0] v);
		logic [VEC_W:0] d;
		d = {1'b0, v} - 9'(OS_BASE);
		return d[MAP_IDX_W-1:0];
	endfunction

endpackage

@@ rtl/interrupt_vector_allocator.sv @@
`timescale 1ns / 1ps

// Channel   Handshake          Ports
// -------   ----------------   --------------------------------------
// command   start & !busy      opcode, vector, handler_id
// result    done (1 cycle)     result_vector, found, handler_out
//
// Allocate scans the used bitmap one byte per cycle, from the first byte of
// the os or external range up to a free bit or its last byte, then done pulses.
// Free and bind finish in the exec state, get goes exec then get (handler table read port), then done.
// busy stays high from the accepted command until the done cycle.
// arst_n clears the bitmap and the handler-table valid bits at once.
// The receiver cannot stall: done marks the result for exactly one cycle.
module interrupt_vector_allocator
	import iva_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              opcode,
	input  logic [VEC_W-1:0]        vector,
	input  logic [15:0]             handler_id,
	output logic                    done,
	output logic [VEC_W-1:0]        result_vector,
	output logic                    found,
	output logic [HANDLER_BITS-1:0] handler_out
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EXEC, ST_GET} state_t;

	state_t                  state_q;
	logic [2:0]              op_q;
	logic [VEC_W-1:0]        vec_q;
	logic [HANDLER_BITS-1:0] hid_q;
	logic [BYTE_W-1:0]       byte_q;
	logic                    done_q;
	logic [VEC_W-1:0]        result_vector_q;
	logic                    found_q;
	logic [HANDLER_BITS-1:0] handler_out_q;

	logic [MAP_BITS-1:0]     used_q;
	logic [STORE_SIZE-1:0]   valid_q;
	logic [HANDLER_BITS-1:0] table_mem [STORE_SIZE];
	logic [HANDLER_BITS-1:0] rd_data_q;
	logic                    rd_valid_q;

	logic [7:0]              cand;
	logic [2:0]              hit_idx;
	logic                    scan_hit;
	logic                    is_alloc_os;
	logic [BYTE_W-1:0]       last_byte;
	logic                    wr_en;
	logic [VEC_W-1:0]        wr_addr;
	logic [HANDLER_BITS-1:0] wr_data;
	logic                    wr_free;

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign result_vector = result_vector_q;
	assign found         = found_q;
	assign handler_out   = handler_out_q;

	assign is_alloc_os = (op_q == OP_ALLOC_OS);
	assign last_byte   = is_alloc_os ? OS_LAST_BYTE : EXT_LAST_BYTE;

	// Free candidates in the current bitmap byte
	always_comb begin
		logic [VEC_W-1:0] v;
		logic             in_lo;
		logic             in_hi;
		for (int i = 0; i < 8; i++) begin
			v     = {byte_q, 3'(i)};
			in_lo = is_alloc_os ? ({1'b0, v} >= 9'(OS_BASE)) : ({1'b0, v} >= 9'(EXT_BASE));
			in_hi = is_alloc_os ? ({1'b0, v} < 9'(EXT_BASE)) : ({1'b0, v} < 9'(EXT_END));
			cand[i] = in_lo && in_hi && vec_exists(v) && vec_has_mark(v)
				&& !used_q[map_index(v)];
		end
	end

	// Lowest free bit of the byte
	always_comb begin
		hit_idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (cand[i]) begin
				hit_idx = 3'(i);
			end
		end
	end

	assign scan_hit = (state_q == ST_SCAN) && (|cand);

	// Table and bitmap write port
	always_comb begin
		wr_free = (state_q == ST_EXEC) && (op_q == OP_FREE);
		wr_en   = scan_hit || ((state_q == ST_EXEC) && vec_exists(vec_q)
			&& ((op_q == OP_FREE) || (op_q == OP_BIND)));
		wr_addr = scan_hit ? {byte_q, hit_idx} : vec_q;
		wr_data = wr_free ? '0 : hid_q;
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= opcode;
						vec_q  <= vector;
						hid_q  <= handler_id[HANDLER_BITS-1:0];
						byte_q <= (opcode == OP_ALLOC_OS) ? OS_FIRST_BYTE : EXT_FIRST_BYTE;
						if ((opcode == OP_ALLOC_OS) || (opcode == OP_ALLOC_EXT)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_SCAN: begin
					if (|cand) begin
						done_q          <= 1'b1;
						result_vector_q <= {byte_q, hit_idx};
						found_q         <= 1'b1;
						handler_out_q   <= hid_q;
						state_q         <= ST_IDLE;
					end else if (byte_q == last_byte) begin
						done_q          <= 1'b1;
						result_vector_q <= '0;
						found_q         <= 1'b0;
						handler_out_q   <= '0;
						state_q         <= ST_IDLE;
					end else begin
						byte_q <= byte_q + 1'b1;
					end
				end
				ST_EXEC: begin
					result_vector_q <= vec_q;
					handler_out_q   <= '0;
					found_q         <= 1'b0;
					unique case (op_q)
						OP_FREE: begin
							done_q  <= 1'b1;
							found_q <= vec_exists(vec_q);
							state_q <= ST_IDLE;
						end
						OP_BIND: begin
							done_q        <= 1'b1;
							found_q       <= vec_exists(vec_q);
							handler_out_q <= vec_exists(vec_q) ? hid_q : '0;
							state_q       <= ST_IDLE;
						end
						OP_GET: begin
							state_q <= ST_GET;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_GET: begin
					done_q          <= 1'b1;
					result_vector_q <= vec_q;
					found_q         <= vec_exists(vec_q);
					handler_out_q   <= (vec_exists(vec_q) && rd_valid_q) ? rd_data_q : '0;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Used bitmap and table valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
			if (vec_has_mark(wr_addr)) begin
				used_q[map_index(wr_addr)] <= !wr_free;
			end
		end
	end

	// Handler table: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_data_q  <= table_mem[vec_q];
		rd_valid_q <= valid_q[vec_q];
	end

	// Checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != ST_IDLE))
		else $error("result strobe without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_os_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q && (op_q == OP_ALLOC_OS)) |->
		(({1'b0, result_vector_q} >= 9'(OS_BASE)) && ({1'b0, result_vector_q} < 9'(EXT_BASE))))
		else $error("os allocation outside its range");

	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q && ((op_q == OP_ALLOC_OS) || (op_q == OP_ALLOC_EXT))) |->
		used_q[map_index(result_vector_q)])
		else $error("allocated vector not marked used");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q && ((op_q == OP_ALLOC_OS) || (op_q == OP_ALLOC_EXT))) |->
		((result_vector_q == '0) && (handler_out_q == '0)))
		else $error("failed allocation returned nonzero fields");

endmodule

@@ sim/vector_table_monitor.sv @@
`timescale 1ns / 1ps

// Watches the command and result channels, keeps its own copy of the used
// bitmap and handler table, and checks each result against the oldest one due.
module vector_table_monitor
	import iva_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [2:0]              opcode,
	input  logic [VEC_W-1:0]        vector,
	input  logic [15:0]             handler_id,
	input  logic                    done,
	input  logic [VEC_W-1:0]        result_vector,
	input  logic                    found,
	input  logic [HANDLER_BITS-1:0] handler_out,
	output int                      fail_count,
	output int                      pending,
	output int                      checked,
	output int                      full_hits
);

	typedef struct packed {
		logic [VEC_W-1:0]        rvec;
		logic                    found;
		logic [HANDLER_BITS-1:0] hout;
	} vector_reply_t;

	vector_reply_t           vector_replies[$];
	bit                      vec_used[STORE_SIZE];
	logic [HANDLER_BITS-1:0] vec_handler[STORE_SIZE];

	function automatic bit has_used_bit(input int v);
		return v >= OS_BASE && v < EXT_END && v < STORE_SIZE;
	endfunction

	function automatic bit vector_present(input int v);
		return v < VECTOR_COUNT && v < STORE_SIZE;
	endfunction

	// One operation against the local tables; returns the reply it must produce
	task automatic predict_vector_op(input logic [2:0] op, input logic [VEC_W-1:0] vec,
			input logic [15:0] hid, output vector_reply_t r);
		logic [HANDLER_BITS-1:0] h;
		int lo;
		int hi;
		bit hit;
		h = HANDLER_BITS'(hid);
		r.rvec = vec;
		r.found = 1'b0;
		r.hout = '0;
		hit = 1'b0;
		case (op)
			OP_ALLOC_OS, OP_ALLOC_EXT: begin
				lo = (op == OP_ALLOC_OS) ? OS_BASE : EXT_BASE;
				hi = (op == OP_ALLOC_OS) ? EXT_BASE : EXT_END;
				// lowest free vector wins
				for (int v = lo; v < hi && !hit; v++) begin
					if (vector_present(v) && has_used_bit(v) && !vec_used[v]) begin
						vec_used[v] = 1'b1;
						vec_handler[v] = h;
						r.rvec = VEC_W'(v);
						hit = 1'b1;
					end
				end
				if (hit) begin
					r.found = 1'b1;
					r.hout = h;
				end else begin
					r.rvec = '0;
				end
			end
			OP_FREE: begin
				if (vector_present(int'(vec))) begin
					if (has_used_bit(int'(vec)))
						vec_used[vec] = 1'b0;
					vec_handler[vec] = '0;
					r.found = 1'b1;
				end
			end
			OP_BIND: begin
				if (vector_present(int'(vec))) begin
					if (has_used_bit(int'(vec)))
						vec_used[vec] = 1'b1;
					vec_handler[vec] = h;
					r.found = 1'b1;
					r.hout = h;
				end
			end
			OP_GET: begin
				if (vector_present(int'(vec))) begin
					r.found = 1'b1;
					r.hout = vec_handler[vec];
				end
			end
			default: begin
				// reserved opcodes leave the tables alone
			end
		endcase
	endtask

	// Results are checked before a command accepted at the same edge is queued
	always @(posedge clk or negedge arst_n) begin : watch
		vector_reply_t exp_r;
		vector_reply_t new_r;
		if (!arst_n) begin
			vector_replies.delete();
			for (int i = 0; i < STORE_SIZE; i++) begin
				vec_used[i] = 1'b0;
				vec_handler[i] = '0;
			end
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
			full_hits <= 0;
		end else begin
			if (done) begin
				if (vector_replies.size() == 0) begin
					$error("result with nothing due: result_vector %0d found %0d handler_out %0h",
						result_vector, found, handler_out);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = vector_replies.pop_front();
					if (result_vector !== exp_r.rvec)
						$error("result_vector: expected %0d, got %0d", exp_r.rvec, result_vector);
					if (found !== exp_r.found)
						$error("found: expected %0d, got %0d", exp_r.found, found);
					if (handler_out !== exp_r.hout)
						$error("handler_out: expected %0h, got %0h", exp_r.hout, handler_out);
					if (result_vector !== exp_r.rvec || found !== exp_r.found ||
							handler_out !== exp_r.hout)
						fail_count <= fail_count + 1;
					checked <= checked + 1;
				end
			end
			if (start && !busy) begin
				predict_vector_op(opcode, vector, handler_id, new_r);
				if ((opcode == OP_ALLOC_OS || opcode == OP_ALLOC_EXT) && !new_r.found)
					full_hits <= full_hits + 1;
				vector_replies.push_back(new_r);
			end
			pending <= vector_replies.size();
		end
	end

endmodule

@@ sim/interrupt_vector_allocator_tb.sv @@
`timescale 1ns / 1ps

module interrupt_vector_allocator_tb;
	import iva_pkg::*;

	localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
	localparam int         STALL_LIMIT       = 2000;
	localparam int         MAX_GAP           = 40;
	localparam int         SETTLE_CYCLES     = 40;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [2:0]              opcode;
	logic [VEC_W-1:0]        vector;
	logic [15:0]             handler_id;
	logic                    done;
	logic [VEC_W-1:0]        result_vector;
	logic                    found;
	logic [HANDLER_BITS-1:0] handler_out;

	int fail_count;
	int pending;
	int checked;
	int full_hits;
	int items_sent;
	int idle_pct;
	int quiet_cycles;

	interrupt_vector_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.vector        (vector),
		.handler_id    (handler_id),
		.done          (done),
		.result_vector (result_vector),
		.found         (found),
		.handler_out   (handler_out)
	);

	vector_table_monitor mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.vector        (vector),
		.handler_id    (handler_id),
		.done          (done),
		.result_vector (result_vector),
		.found         (found),
		.handler_out   (handler_out),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.full_hits     (full_hits)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: cycles with neither a command nor a result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("interrupt_vector_allocator_tb: FAIL");
			$finish;
		end
	end

	// Present one item at the falling edge and hold it until taken; start is left
	// high, unless the idle draw drops it for a gap, so a following item can replace it in the same step.
	task automatic send_item(input logic [2:0] op, input logic [VEC_W-1:0] vec,
			input logic [15:0] hid);
		start <= 1'b1;
		opcode <= op;
		vector <= vec;
		handler_id <= hid;
		do @(posedge clk); while (busy);
		items_sent++;
		@(negedge clk);
		if (int'($urandom_range(0, 99)) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
		end
	endtask

	// Hold off until every result due has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [VEC_W-1:0] pick_vector();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			return VEC_W'($urandom_range(0, 255));
		else if (sel < 65)
			return VEC_W'($urandom_range(OS_BASE, EXT_BASE - 1));
		else
			return VEC_W'($urandom_range(EXT_BASE, EXT_END - 1));
	endfunction

	function automatic logic [15:0] pick_handler();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 16'h0000;
		else if (sel == 1)
			return 16'hffff;
		else
			return 16'($urandom_range(0, 65535));
	endfunction

	// Mostly allocate/free churn, with binds, reads and the odd reserved code
	task automatic send_random_item();
		int sel;
		logic [2:0] op;
		sel = $urandom_range(0, 99);
		if (sel < 20)
			op = OP_ALLOC_OS;
		else if (sel < 45)
			op = OP_ALLOC_EXT;
		else if (sel < 65)
			op = OP_FREE;
		else if (sel < 80)
			op = OP_BIND;
		else if (sel < 95)
			op = OP_GET;
		else
			op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
		send_item(op, pick_vector(), pick_handler());
	endtask

	initial begin
		int phase_idle[4];
		int burst;
		phase_idle = '{0, 60, 0, 33};
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_ALLOC_OS;
		vector = '0;
		handler_id = '0;
		items_sent = 0;
		idle_pct = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: low and top vectors, reserved codes, os range run dry
		send_item(OP_GET, 8'd0, 16'h0000);
		send_item(OP_BIND, 8'd0, 16'hffff);
		send_item(OP_GET, 8'd0, 16'h0000);
		send_item(OP_BIND, 8'hff, 16'h5a5a);
		send_item(OP_FREE, 8'hff, 16'hffff);
		send_item(OP_GET, 8'hff, 16'hffff);
		for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
			send_item(3'(op), 8'hff, 16'hffff);
		for (int i = 0; i <= EXT_BASE - OS_BASE; i++)
			send_item(OP_ALLOC_OS, 8'hff, (i == 0) ? 16'h0000 : 16'(16'hffff - i * 16'h0f0f));
		send_item(OP_ALLOC_EXT, 8'd0, 16'hffff);
		wait_drained();

		// Random phases under different sender idling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			// first phase runs the external range dry, later ones just burst
			burst = (ph == 0) ? (EXT_END - EXT_BASE + 4) : $urandom_range(0, 40);
			for (int i = 0; i < burst; i++)
				send_item(OP_ALLOC_EXT, pick_vector(), pick_handler());
			for (int i = 0; i < 380; i++)
				send_random_item();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d items across four idling phases; %0d results checked,",
			items_sent, checked);
		$display("%0d allocations hit a full range.", full_hits);
		if (fail_count == 0 && pending == 0)
			$display("interrupt_vector_allocator_tb: PASS");
		else
			$display("interrupt_vector_allocator_tb: FAIL");
		$finish;
	end

endmodule

@@ interrupt_vector_allocator.f @@
rtl/iva_pkg.sv
rtl/interrupt_vector_allocator.sv
sim/vector_table_monitor.sv
sim/interrupt_vector_allocator_tb.sv
